@@ rtl/error_history_ring_log_defines.svh @@
// assertion macros for the error history ring log rtl
`ifndef ERROR_HISTORY_RING_LOG_DEFINES_SVH
`define ERROR_HISTORY_RING_LOG_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ERL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("error history ring log check failed");

// next-cycle implication, checked out of reset
`define ERL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("error history ring log check failed");

`endif

@@ rtl/erl_pkg.sv @@
package erl_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int IDX_W         = $clog2(HISTORY_DEPTH);
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
   // wide enough for both the internal counts and the 5-bit result fields
   localparam int WIDE_W        = (CNT_W > 5) ? CNT_W : 5;

   localparam logic [2:0] SEV_CRITICAL = 3'd3;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_COUNT  = 2'd3
   } command_type;

   typedef enum logic {
      ST_IDLE,
      ST_COUNT
   } state_type;

   // one history record, 59 bits
   typedef struct packed {
      logic [7:0]  code;
      logic [2:0]  severity;
      logic [31:0] stamp;
      logic [15:0] line;
   } entry_type;

   // move controls broadcast to every cell
   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

endpackage

@@ rtl/error_history_ring_log.sv @@
// channel | direction | beat contents
// req     | in        | command, error code, severity, source line, entry index, time
// rsp     | out       | read entry, newest code, held count, counters, matches, elapsed time
//
// record, read and clear: accepted beat gives its rsp beat in the next cycle
// count severity: one cell tapped per cycle as the row rotates, rsp beat registered
// once the last cell has been tapped
// one item at a time: req is stalled while an item is in work or its rsp beat waits,
// the next req beat can be taken in the cycle after the rsp beat is taken
// reset (synchronous) empties the history and zeroes the history counters
`include "error_history_ring_log_defines.svh"

module error_history_ring_log (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_error_code,
   input  logic [2:0]  req_severity_level,
   input  logic [15:0] req_source_line,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_entry_valid,
   output logic [7:0]  rsp_entry_code,
   output logic [2:0]  rsp_entry_severity,
   output logic [31:0] rsp_entry_time,
   output logic [15:0] rsp_entry_line,
   output logic [7:0]  rsp_newest_code,
   output logic [4:0]  rsp_held_entries,
   output logic [31:0] rsp_lifetime_errors,
   output logic [31:0] rsp_critical_errors,
   output logic [4:0]  rsp_severity_matches,
   output logic [31:0] rsp_since_last_ms
);
   import erl_pkg::*;

   // cell 0 holds the newest record, cell held-1 the oldest
   entry_type     cell_q [HISTORY_DEPTH];
   entry_type     new_entry;
   cell_ctrl_type cell_ctrl;

   // control state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [31:0]       total_ff, total_in;
   logic [31:0]       crit_ff, crit_in;
   logic [31:0]       last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload and count working registers
   logic [2:0]        count_sev_ff, count_sev_in;
   logic [CNT_W-1:0]  matches_ff, matches_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic              rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [7:0]        rsp_newest_ff, rsp_newest_in;
   logic [4:0]        rsp_held_ff, rsp_held_in;
   logic [31:0]       rsp_total_ff, rsp_total_in;
   logic [31:0]       rsp_crit_ff, rsp_crit_in;
   logic [31:0]       rsp_since_ff, rsp_since_in;

   command_type       cmd;
   logic              accept;
   logic              rec_hit;
   logic [WIDE_W-1:0] held_wide;
   logic [WIDE_W-1:0] held_in_wide;
   logic [WIDE_W-1:0] matches_wide;
   logic              rd_valid;
   logic [CNT_W-1:0]  rd_pos;
   logic [IDX_W-1:0]  rd_slot;
   entry_type         rd_entry;
   logic              step_last;
   logic              count_hit;

   // ---------------------------------------------------------------- cell row
   assign new_entry = '{code: req_error_code, severity: req_severity_level,
                        stamp: req_now_ms, line: req_source_line};

   assign cell_ctrl.shift  = rec_hit;
   assign cell_ctrl.rotate = (state_ff == ST_COUNT);

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      entry_type newer_src;
      entry_type older_src;
      if (i == 0) begin : g_head
         assign newer_src = new_entry;
      end else begin : g_body
         assign newer_src = cell_q[i-1];
      end
      // the oldest end wraps back to the head so a full rotation restores order
      if (i == HISTORY_DEPTH - 1) begin : g_tail
         assign older_src = cell_q[0];
      end else begin : g_inner
         assign older_src = cell_q[i+1];
      end
      erl_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .from_newer (newer_src),
         .from_older (older_src),
         .entry      (cell_q[i])
      );
   end

   // ---------------------------------------------------------------- decode
   assign cmd     = command_type'(req_command);
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept  = req_valid && !req_stall;
   // a zero code is not an error and leaves the history and counters alone
   assign rec_hit = accept && (cmd == CMD_RECORD) && (req_error_code != 8'd0);

   assign held_wide    = WIDE_W'(held_ff);
   assign held_in_wide = WIDE_W'(held_in);
   assign matches_wide = WIDE_W'(matches_ff);

   // logical index 0 is the oldest, which sits at cell held-1
   assign rd_valid = WIDE_W'(req_entry_index) < held_wide;
   assign rd_pos   = held_ff - CNT_W'(1) - CNT_W'(req_entry_index);
   assign rd_slot  = rd_pos[IDX_W-1:0];
   assign rd_entry = cell_q[rd_slot];

   // during a count, cell 0 holds the record that started at cell step
   assign step_last = (step_ff == IDX_W'(HISTORY_DEPTH - 1));
   assign count_hit = (WIDE_W'(step_ff) < held_wide) &&
                      (cell_q[0].severity == count_sev_ff);

   // ---------------------------------------------------------------- history counters
   always_comb begin
      held_in  = held_ff;
      total_in = total_ff;
      crit_in  = crit_ff;
      last_in  = last_ff;
      if (rec_hit) begin
         if (held_ff != CNT_W'(HISTORY_DEPTH)) begin
            held_in = held_ff + CNT_W'(1);
         end
         total_in = total_ff + 32'd1;
         last_in  = req_now_ms;
         if (req_severity_level >= SEV_CRITICAL) begin
            crit_in = crit_ff + 32'd1;
         end
      end else if (accept && (cmd == CMD_CLEAR)) begin
         // lifetime counters survive a clear
         held_in = '0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in           = state_ff;
      step_in            = step_ff;
      matches_in         = matches_ff;
      count_sev_in       = count_sev_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_entry_in       = rsp_entry_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_newest_in      = rsp_newest_ff;
      rsp_held_in        = rsp_held_ff;
      rsp_total_in       = rsp_total_ff;
      rsp_crit_in        = rsp_crit_ff;
      rsp_since_in       = rsp_since_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // status fields are taken after this item's update
               rsp_entry_valid_in = (cmd == CMD_READ) && rd_valid;
               rsp_entry_in       = rsp_entry_valid_in ? rd_entry : '0;
               if (rec_hit) begin
                  rsp_newest_in = req_error_code;
               end else if ((cmd != CMD_CLEAR) && (held_ff != '0)) begin
                  rsp_newest_in = cell_q[0].code;
               end else begin
                  rsp_newest_in = 8'd0;
               end
               rsp_held_in  = held_in_wide[4:0];
               rsp_total_in = total_in;
               rsp_crit_in  = crit_in;
               // a zero last time means no error seen yet
               rsp_since_in = (last_in == 32'd0) ? req_now_ms : (req_now_ms - last_in);
               matches_in   = '0;
               if (cmd == CMD_COUNT) begin
                  state_in     = ST_COUNT;
                  step_in      = '0;
                  count_sev_in = req_severity_level;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_COUNT: begin
            step_in    = step_ff + IDX_W'(1);
            matches_in = matches_ff + CNT_W'(count_hit);
            if (step_last) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         held_ff      <= '0;
         total_ff     <= '0;
         crit_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         crit_ff      <= crit_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      count_sev_ff       <= count_sev_in;
      matches_ff         <= matches_in;
      rsp_entry_ff       <= rsp_entry_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_newest_ff      <= rsp_newest_in;
      rsp_held_ff        <= rsp_held_in;
      rsp_total_ff       <= rsp_total_in;
      rsp_crit_ff        <= rsp_crit_in;
      rsp_since_ff       <= rsp_since_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entry_valid      = rsp_entry_valid_ff;
   assign rsp_entry_code       = rsp_entry_ff.code;
   assign rsp_entry_severity   = rsp_entry_ff.severity;
   assign rsp_entry_time       = rsp_entry_ff.stamp;
   assign rsp_entry_line       = rsp_entry_ff.line;
   assign rsp_newest_code      = rsp_newest_ff;
   assign rsp_held_entries     = rsp_held_ff;
   assign rsp_lifetime_errors  = rsp_total_ff;
   assign rsp_critical_errors  = rsp_crit_ff;
   assign rsp_severity_matches = matches_wide[4:0];
   assign rsp_since_last_ms    = rsp_since_ff;

   // ---------------------------------------------------------------- checks
   `ERL_ASSERT_IMPL(a_held_bound, 1'b1, held_ff <= CNT_W'(HISTORY_DEPTH))
   `ERL_ASSERT_IMPL(a_count_no_rsp, state_ff == ST_COUNT, !rsp_valid_ff)
   `ERL_ASSERT_NEXT(a_count_done, (state_ff == ST_COUNT) && step_last, rsp_valid_ff && (state_ff == ST_IDLE))
   `ERL_ASSERT_NEXT(a_clear_empty, accept && (cmd == CMD_CLEAR), held_ff == '0)
   `ERL_ASSERT_NEXT(a_total_bump, rec_hit, total_ff == ($past(total_ff) + 32'd1))

endmodule

@@ rtl/erl_cell.sv @@
module erl_cell (
   input  logic                  clock,
   input  erl_pkg::cell_ctrl_type ctrl,
   input  erl_pkg::entry_type    from_newer,
   input  erl_pkg::entry_type    from_older,
   output erl_pkg::entry_type    entry
);
   import erl_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // shift ages the row by one, rotate walks it for a count
   always_comb begin
      priority if (ctrl.shift) begin
         entry_in = from_newer;
      end else if (ctrl.rotate) begin
         entry_in = from_older;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
